// ----- rtl/wsu_pkg.sv -----
// Package for the WebSocket frame unmasker.
// Holds parse phase and status codes and the result beat type.
// No dependencies.
`default_nettype none

package wsu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned CountW  = 4;
  localparam int unsigned IdxW    = 2;

  localparam logic [7:0] FinBit   = 8'h80;
  localparam logic [6:0] Len7Mask = 7'h7F;
  localparam logic [6:0] Len16    = 7'd126;
  localparam logic [6:0] Len64    = 7'd127;

  localparam logic [CountW-1:0] Need16  = 4'd2;
  localparam logic [CountW-1:0] Need64  = 4'd8;
  localparam logic [CountW-1:0] NeedKey = 4'd4;

  typedef enum logic [6:0] {
    PH_HDR0    = 7'b0000001,
    PH_HDR1    = 7'b0000010,
    PH_EXT16   = 7'b0000100,
    PH_EXT64   = 7'b0001000,
    PH_MASK    = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_SKIP    = 7'b1000000
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FINAL = 3'd1,
    ST_UNMASKED  = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             last_of_frame;
    status_e          status;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/wsu_out_buf.sv -----
// Two-entry output buffer (output register plus skid register).
// Uses res_t from wsu_pkg.
`default_nettype none

module wsu_out_buf
  import wsu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t push_data_i,
  output logic      ready_o,
  output logic      valid_o,
  input  wire logic take_i,
  output res_t      data_o
);

  logic out_valid_q, skid_valid_q;
  res_t out_data_q, skid_data_q;
  logic out_free;

  assign out_free = !out_valid_q || take_i;
  assign ready_o  = !skid_valid_q;
  assign valid_o  = out_valid_q;
  assign data_o   = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : push_data_i;
    end else if (push_i) begin
      skid_data_q <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/websocket_frame_unmask.sv -----
// Top level: WebSocket client frame header parser and payload unmasker.
// Depends on wsu_pkg and wsu_out_buf.
//
// channel   dir  tdata             tlast           tuser
// s_axis    in   in_byte[7:0]      buffer_end      -
// m_axis    out  payload_byte[7:0] last_of_frame   status[2:0]
//
// One input beat per cycle while s_axis_tready is high; each beat updates the
// parse state when it is accepted and its result, if any, is registered in the output buffer.
// The 64-bit remaining-length decrement and zero test set the path length.
// Reset returns the parser to the first header byte; no clearing pass.
// A two-entry output buffer holds a result pushed while m_axis stalls;
// s_axis_tready drops only while both entries hold results.
`default_nettype none

module websocket_frame_unmask
  import wsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // in_byte[7:0]
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // payload_byte[7:0]
  output logic            m_axis_tlast,
  output logic [2:0]      m_axis_tuser    // status[2:0]
);

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] hc_q, hc_d, hc_inc;
  logic [LenW-1:0]   rem_q, rem_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [IdxW-1:0]   idx_q, idx_d;

  logic       accept, b_end, err, res_valid;
  logic [7:0] b, m;
  logic [6:0] len7;
  status_e    err_code;
  res_t       res, out_res;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign b      = s_axis_tdata;
  assign b_end  = s_axis_tlast;
  assign len7   = b[6:0] & Len7Mask;
  assign hc_inc = hc_q + 4'd1;

  always_comb begin
    case (idx_q)
      2'd0:    m = key_q[31:24];
      2'd1:    m = key_q[23:16];
      2'd2:    m = key_q[15:8];
      default: m = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    hc_d      = hc_q;
    rem_d     = rem_q;
    key_d     = key_q;
    idx_d     = idx_q;
    err       = 1'b0;
    err_code  = ST_TRUNCATED;
    res_valid = 1'b0;
    res       = '{payload_byte: 8'h00, last_of_frame: 1'b0, status: ST_OK};
    case (phase_q)
      PH_HDR0: begin
        hc_d = '0;
        if (b_end) begin
          err = 1'b1;
        end else if ((b & FinBit) != FinBit) begin
          err      = 1'b1;
          err_code = ST_NOT_FINAL;
        end else begin
          phase_d = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if ((b & FinBit) != FinBit) begin
          err      = 1'b1;
          err_code = ST_UNMASKED;
        end else if (b_end) begin
          err = 1'b1;
        end else begin
          hc_d  = '0;
          rem_d = '0;
          key_d = '0;
          if (len7 == Len16) begin
            phase_d = PH_EXT16;
          end else if (len7 == Len64) begin
            phase_d = PH_EXT64;
          end else begin
            rem_d   = {{(LenW-7){1'b0}}, len7};
            phase_d = PH_MASK;
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        if (b_end) begin
          err = 1'b1;
        end else begin
          rem_d = {rem_q[LenW-9:0], b};
          hc_d  = hc_inc;
          if (hc_inc >= ((phase_q == PH_EXT16) ? Need16 : Need64)) begin
            hc_d    = '0;
            phase_d = PH_MASK;
          end
        end
      end
      PH_MASK: begin
        key_d = {key_q[KeyW-9:0], b};
        if (hc_inc < NeedKey) begin
          hc_d = hc_inc;
          err  = b_end;
        end else begin
          hc_d  = '0;
          idx_d = '0;
          if (rem_q == '0) begin
            err      = 1'b1;
            err_code = ST_EMPTY;
          end else if (b_end) begin
            err = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        rem_d = rem_q - {{(LenW-1){1'b0}}, 1'b1};
        idx_d = idx_q + 2'd1;
        if (rem_q == {{(LenW-1){1'b0}}, 1'b1}) begin
          res_valid = 1'b1;
          res       = '{payload_byte: b ^ m, last_of_frame: 1'b1, status: ST_OK};
          phase_d   = b_end ? PH_HDR0 : PH_SKIP;
        end else if (b_end) begin
          err = 1'b1;
        end else begin
          res_valid = 1'b1;
          res       = '{payload_byte: b ^ m, last_of_frame: 1'b0, status: ST_OK};
        end
      end
      default: begin
        if (b_end) begin
          phase_d = PH_HDR0;
        end
      end
    endcase
    if (err) begin
      res_valid = 1'b1;
      res       = '{payload_byte: 8'h00, last_of_frame: 1'b1, status: err_code};
      phase_d   = b_end ? PH_HDR0 : PH_SKIP;
      hc_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      hc_q    <= '0;
      rem_q   <= '0;
      key_q   <= '0;
      idx_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      idx_q   <= idx_d;
    end
  end

  wsu_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .take_i      (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = out_res.payload_byte;
  assign m_axis_tlast = out_res.last_of_frame;
  assign m_axis_tuser = out_res.status;

endmodule

`default_nettype wire
